FILE: rtl/core/bcd_pkg.sv
// Shared constants and controller/datapath interface types for the block cache directory.
package bcd_pkg;

  // Field widths
  localparam int OP_W       = 2;
  localparam int BLK_W      = 32;
  localparam int SLOT_OUT_W = 4;

  // Request operations
  localparam logic [OP_W-1:0] OP_READ       = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE      = 2'd1;
  localparam logic [OP_W-1:0] OP_INVALIDATE = 2'd2;
  localparam logic [OP_W-1:0] OP_SYNC       = 2'd3;

  // Sync gives at most this many result beats per request
  localparam int MAX_RESULTS = 16;
  localparam int RES_CNT_W   = 5;

  // Commands from controller to datapath
  typedef struct packed {
    logic start;    // latch the request, clear the sync walk
    logic compare;  // register the per-slot tag match
    logic decide;   // register hit slot and victim slot
    logic commit;   // update directory and load the result beat
    logic scan;     // one step of the sync walk
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;   // result register can take a beat this cycle
    logic scan_done;  // the current sync step finishes the request
  } dpath_sts_t;

endpackage

FILE: rtl/core/block_cache_directory.sv
// Top level of the block cache directory: controller plus datapath.
//
// Usage: requests arrive on the in_ channel (valid/ready), one beat each,
// carrying an operation (read, write, invalidate, sync) and a block number.
// Results leave on the out_ channel (valid/ready); out_last marks the final
// beat of a request. Read, write and invalidate give one beat; sync gives one
// beat per dirty slot (at most 16), or one empty beat if nothing is dirty.
// Sequencing: read, write and invalidate pass through the compare, decide and
// commit steps of the controller (registered tag match, then registered slot
// choice) before the next accept; the result beat is loaded at commit. Sync
// walks one slot per cycle while the result register is free, and finishes
// at the last slot written back, or at the last slot if nothing is dirty.
// One request is in flight at a time.
// Reset: all slots invalid and clean, replacement hand at slot 0, no result
// pending; no clearing pass is needed.
// Stalls: a finished beat sits in the result register until out_ready. The
// next request can still be accepted and looked up, but its commit, like
// each sync step, waits for the register to drain, and in_ready stays low
// until that step is done.
module block_cache_directory #(
  parameter int SLOTS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bcd_pkg::OP_W-1:0]          in_operation,
  input  logic [bcd_pkg::BLK_W-1:0]         in_block_number,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bcd_pkg::SLOT_OUT_W-1:0]    out_slot_index,
  output logic                              out_hit,
  output logic                              out_fill_needed,
  output logic                              out_writeback_needed,
  output logic [bcd_pkg::BLK_W-1:0]         out_writeback_block,
  output logic                              out_last
);

  bcd_pkg::ctrl_cmd_t  cmd;
  bcd_pkg::dpath_sts_t sts;

  // Sequencer
  bcd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // Directory and result register
  bcd_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_operation         (in_operation),
    .in_block_number      (in_block_number),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_slot_index       (out_slot_index),
    .out_hit              (out_hit),
    .out_fill_needed      (out_fill_needed),
    .out_writeback_needed (out_writeback_needed),
    .out_writeback_block  (out_writeback_block),
    .out_last             (out_last)
  );

endmodule

FILE: rtl/core/bcd_ctrl.sv
// Controller state machine for the block cache directory.
module bcd_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [bcd_pkg::OP_W-1:0]    in_operation,
  output logic                        in_ready,
  input  bcd_pkg::dpath_sts_t         sts,
  output bcd_pkg::ctrl_cmd_t          cmd
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_CMP     = 3'd1;
  localparam logic [2:0] ST_DEC     = 3'd2;
  localparam logic [2:0] ST_COMMIT  = 3'd3;
  localparam logic [2:0] ST_SCAN    = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.start = 1'b1;
          state_nxt = (in_operation == bcd_pkg::OP_SYNC) ? ST_SCAN : ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.compare = 1'b1;
        state_nxt   = ST_DEC;
      end
      ST_DEC: begin
        cmd.decide = 1'b1;
        state_nxt  = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (sts.out_free) begin
          cmd.scan = 1'b1;
          if (sts.scan_done) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A lookup request walks compare, decide, commit in order
  a_cmp_to_dec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CMP |=> state_r == ST_DEC)
    else $error("compare not followed by decide");

  a_dec_to_commit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DEC |=> state_r == ST_COMMIT)
    else $error("decide not followed by commit");

  // At most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command");

endmodule

FILE: rtl/core/bcd_dpath.sv
// Datapath for the block cache directory: tags, marks, hand, lookup and result register.
module bcd_dpath #(
  parameter int SLOTS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bcd_pkg::ctrl_cmd_t                cmd,
  output bcd_pkg::dpath_sts_t               sts,
  input  logic [bcd_pkg::OP_W-1:0]          in_operation,
  input  logic [bcd_pkg::BLK_W-1:0]         in_block_number,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bcd_pkg::SLOT_OUT_W-1:0]    out_slot_index,
  output logic                              out_hit,
  output logic                              out_fill_needed,
  output logic                              out_writeback_needed,
  output logic [bcd_pkg::BLK_W-1:0]         out_writeback_block,
  output logic                              out_last
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  // Directory state
  logic [bcd_pkg::BLK_W-1:0] tag_r   [SLOTS];
  logic [bcd_pkg::BLK_W-1:0] tag_nxt [SLOTS];
  logic [SLOTS-1:0]          valid_r, valid_nxt;
  logic [SLOTS-1:0]          dirty_r, dirty_nxt;
  logic [SLOT_W-1:0]         hand_r, hand_nxt;

  // Request and lookup state
  logic [bcd_pkg::OP_W-1:0]  op_r, op_nxt;
  logic [bcd_pkg::BLK_W-1:0] blk_r, blk_nxt;
  logic [SLOTS-1:0]          match_r, match_nxt;
  logic                      hit_r, hit_nxt;
  logic [SLOT_W-1:0]         hit_idx_r, hit_idx_nxt;
  logic [SLOT_W-1:0]         victim_r, victim_nxt;
  logic                      use_hand_r, use_hand_nxt;

  // Sync walk
  logic [SLOT_W-1:0]                 scan_idx_r, scan_idx_nxt;
  logic [bcd_pkg::RES_CNT_W-1:0]     cnt_r, cnt_nxt;

  // Result register
  logic                              oval_r, oval_nxt;
  logic [SLOT_W-1:0]                 oslot_r, oslot_nxt;
  logic                              ohit_r, ohit_nxt;
  logic                              ofill_r, ofill_nxt;
  logic                              owb_r, owb_nxt;
  logic [bcd_pkg::BLK_W-1:0]         oblk_r, oblk_nxt;
  logic                              olast_r, olast_nxt;

  // Combinational helpers
  logic [SLOTS-1:0]  eq_vec;
  logic              any_match;
  logic [SLOT_W-1:0] match_idx;
  logic              any_free;
  logic [SLOT_W-1:0] vacant_idx;
  logic [SLOTS-1:0]  above;
  logic              cur_dirty;
  logic              at_end;
  logic              sync_last;
  logic              emit;
  logic [SLOT_W-1:0] hand_inc;

  assign sts.out_free = !oval_r || out_ready;

  // Per-slot tag compare
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      eq_vec[i] = valid_r[i] && (tag_r[i] == blk_r);
    end
  end

  // Lowest matching slot and lowest free slot
  always_comb begin
    match_idx  = '0;
    vacant_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        match_idx = SLOT_W'(i);
      end
      if (!valid_r[i]) begin
        vacant_idx = SLOT_W'(i);
      end
    end
  end
  assign any_match = |match_r;
  assign any_free  = ~&valid_r;
  assign hand_inc  = (hand_r == LAST_SLOT) ? '0 : hand_r + 1'b1;

  // Sync walk: is this slot the final one written back
  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      above[j] = (j > int'(scan_idx_r));
    end
  end
  assign cur_dirty     = dirty_r[scan_idx_r];
  assign at_end        = (scan_idx_r == LAST_SLOT);
  assign sync_last     = !(|(dirty_r & above)) ||
                         (cnt_r == bcd_pkg::RES_CNT_W'(bcd_pkg::MAX_RESULTS - 1));
  assign sts.scan_done = cur_dirty ? sync_last : at_end;

  // Next-state logic
  always_comb begin
    tag_nxt      = tag_r;
    valid_nxt    = valid_r;
    dirty_nxt    = dirty_r;
    hand_nxt     = hand_r;
    op_nxt       = op_r;
    blk_nxt      = blk_r;
    match_nxt    = match_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    victim_nxt   = victim_r;
    use_hand_nxt = use_hand_r;
    scan_idx_nxt = scan_idx_r;
    cnt_nxt      = cnt_r;
    oslot_nxt    = oslot_r;
    ohit_nxt     = ohit_r;
    ofill_nxt    = ofill_r;
    owb_nxt      = owb_r;
    oblk_nxt     = oblk_r;
    olast_nxt    = olast_r;
    emit         = 1'b0;

    // Latch the request
    if (cmd.start) begin
      op_nxt       = in_operation;
      blk_nxt      = in_block_number;
      scan_idx_nxt = '0;
      cnt_nxt      = '0;
    end

    if (cmd.compare) begin
      match_nxt = eq_vec;
    end

    if (cmd.decide) begin
      hit_nxt      = any_match;
      hit_idx_nxt  = match_idx;
      victim_nxt   = any_free ? vacant_idx : hand_r;
      use_hand_nxt = !any_free;
    end

    // Lookup result: hit, fill with optional writeback, or invalidate
    if (cmd.commit) begin
      emit      = 1'b1;
      olast_nxt = 1'b1;
      ofill_nxt = 1'b0;
      owb_nxt   = 1'b0;
      oblk_nxt  = '0;
      ohit_nxt  = hit_r;
      oslot_nxt = hit_r ? hit_idx_r : '0;
      if (op_r == bcd_pkg::OP_INVALIDATE) begin
        if (hit_r) begin
          valid_nxt[hit_idx_r] = 1'b0;
          dirty_nxt[hit_idx_r] = 1'b0;
        end
      end else if (hit_r) begin
        if (op_r == bcd_pkg::OP_WRITE) begin
          dirty_nxt[hit_idx_r] = 1'b1;
        end
      end else begin
        oslot_nxt           = victim_r;
        ofill_nxt           = 1'b1;
        owb_nxt             = dirty_r[victim_r];
        oblk_nxt            = dirty_r[victim_r] ? tag_r[victim_r] : '0;
        tag_nxt[victim_r]   = blk_r;
        valid_nxt[victim_r] = 1'b1;
        dirty_nxt[victim_r] = (op_r == bcd_pkg::OP_WRITE);
        if (use_hand_r) begin
          hand_nxt = hand_inc;
        end
      end
    end

    // Sync step: write back a dirty slot, or close with an empty beat
    if (cmd.scan) begin
      if (cur_dirty) begin
        emit                  = 1'b1;
        oslot_nxt             = scan_idx_r;
        ohit_nxt              = 1'b0;
        ofill_nxt             = 1'b0;
        owb_nxt               = 1'b1;
        oblk_nxt              = tag_r[scan_idx_r];
        olast_nxt             = sync_last;
        dirty_nxt[scan_idx_r] = 1'b0;
        cnt_nxt               = cnt_r + 1'b1;
      end else if (at_end && cnt_r == '0) begin
        emit      = 1'b1;
        oslot_nxt = '0;
        ohit_nxt  = 1'b0;
        ofill_nxt = 1'b0;
        owb_nxt   = 1'b0;
        oblk_nxt  = '0;
        olast_nxt = 1'b1;
      end
      if (!at_end) begin
        scan_idx_nxt = scan_idx_r + 1'b1;
      end
    end

    // Result register valid
    if (emit) begin
      oval_nxt = 1'b1;
    end else if (out_ready) begin
      oval_nxt = 1'b0;
    end else begin
      oval_nxt = oval_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      dirty_r <= '0;
      hand_r  <= '0;
      oval_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      dirty_r <= dirty_nxt;
      hand_r  <= hand_nxt;
      oval_r  <= oval_nxt;
    end
  end

  // Payload state
  always_ff @(posedge clk) begin
    tag_r      <= tag_nxt;
    op_r       <= op_nxt;
    blk_r      <= blk_nxt;
    match_r    <= match_nxt;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    victim_r   <= victim_nxt;
    use_hand_r <= use_hand_nxt;
    scan_idx_r <= scan_idx_nxt;
    cnt_r      <= cnt_nxt;
    oslot_r    <= oslot_nxt;
    ohit_r     <= ohit_nxt;
    ofill_r    <= ofill_nxt;
    owb_r      <= owb_nxt;
    oblk_r     <= oblk_nxt;
    olast_r    <= olast_nxt;
  end

  // Output ports
  assign out_valid            = oval_r;
  assign out_slot_index       = bcd_pkg::SLOT_OUT_W'(oslot_r);
  assign out_hit              = ohit_r;
  assign out_fill_needed      = ofill_r;
  assign out_writeback_needed = owb_r;
  assign out_writeback_block  = oblk_r;
  assign out_last             = olast_r;

  // Dirty slots are always valid
  a_dirty_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (dirty_r & ~valid_r) == '0)
    else $error("dirty mark on invalid slot");

  // The requested block is never held by two valid slots
  a_unique_tag: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(eq_vec))
    else $error("block present in more than one slot");

  // A beat is only loaded into a free result register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> sts.out_free)
    else $error("result beat overwritten");

endmodule
